[design/etsp_pkg.sv]
// Package for the EEPROM transfer splitter: sizes, status and register codes,
// the classified command type and the back-end state type.
// No dependencies; every other design file imports it.
package etsp_pkg;

   // Address space and request limits.
   localparam int ADDR_W      = 19;
   localparam int START_W     = 18;
   localparam int COUNT_W     = 13;
   localparam int STOP_W      = 20;
   localparam int WORD_W      = 16;
   localparam int OFFSET_W    = 12;
   localparam int DEV_W       = 8;
   localparam int STATUS_W    = 2;

   localparam int PAGE_BYTES  = 128;
   localparam int DIE_BYTES   = 65536;
   localparam int MAX_REQUEST = 4096;
   localparam int PAGE_LOG2   = $clog2(PAGE_BYTES);
   localparam int DIE_LOG2    = $clog2(DIE_BYTES);

   // At most this many chunks leave for one request.
   localparam int MAX_RESULTS = 33;
   localparam int CHUNK_CNT_W = $clog2(MAX_RESULTS);

   // Register file.
   localparam logic [ADDR_W-1:0] TOP_LIMIT_RESET   = 19'h3FFF0;
   localparam logic [DEV_W-1:0]  DEVICE_BASE_RESET = 8'hA0;
   localparam logic CSR_TOP_LIMIT   = 1'b0;
   localparam logic CSR_DEVICE_BASE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LENGTH = 2'd2;

   // Command queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // A classified request as it waits in the queue.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_write;
      logic [START_W-1:0]  start_addr;
      logic [ADDR_W-1:0]   end_addr;
   } chunk_cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   // I2C die select code for a die index; the index wraps over four dies.
   function automatic logic [DEV_W-1:0] die_code(input logic [1:0] die);
      logic [DEV_W-1:0] code;
      unique case (die)
         2'd0: code = 8'h08;
         2'd1: code = 8'h0A;
         2'd2: code = 8'h0C;
         default: code = 8'h0E;
      endcase
      return code;
   endfunction

endpackage

[design/etsp_front.sv]
// Front end of the EEPROM transfer splitter: register file and request
// classification (range and length checks). Depends on etsp_pkg.
module etsp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [etsp_pkg::START_W-1:0]    req_start_address,
   input  logic [etsp_pkg::COUNT_W-1:0]    req_byte_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [etsp_pkg::ADDR_W-1:0]     csr_wdata,
   output logic [etsp_pkg::DEV_W-1:0]      device_base,
   output logic                            push_valid,
   input  logic                            push_ready,
   output etsp_pkg::chunk_cmd_type         push_cmd
);
   import etsp_pkg::*;

   logic [ADDR_W-1:0] top_limit_ff, top_limit_in;
   logic [DEV_W-1:0]  device_base_ff, device_base_in;
   logic [ADDR_W-1:0] end_addr;

   // Register writes are always accepted.
   assign csr_ready = 1'b1;

   always_comb begin
      top_limit_in   = top_limit_ff;
      device_base_in = device_base_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TOP_LIMIT:   top_limit_in = csr_wdata;
            CSR_DEVICE_BASE: device_base_in = csr_wdata[DEV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_limit_ff   <= TOP_LIMIT_RESET;
         device_base_ff <= DEVICE_BASE_RESET;
      end else begin
         top_limit_ff   <= top_limit_in;
         device_base_ff <= device_base_in;
      end
   end

   assign device_base = device_base_ff;

   // Classify the incoming transaction; range beats length.
   assign end_addr = ADDR_W'(req_start_address) + ADDR_W'(req_byte_count);

   always_comb begin
      push_cmd.is_write   = req_opcode;
      push_cmd.start_addr = req_start_address;
      push_cmd.end_addr   = end_addr;
      if ((ADDR_W'(req_start_address) > top_limit_ff) || (end_addr > top_limit_ff)) begin
         push_cmd.status = STATUS_RANGE;
      end else if (req_byte_count > COUNT_W'(MAX_REQUEST)) begin
         push_cmd.status = STATUS_LENGTH;
      end else begin
         push_cmd.status = STATUS_OK;
      end
   end

   assign push_valid = req_valid;
   assign req_stall  = !push_ready;

endmodule

[design/etsp_queue.sv]
// Short command queue between the front and back ends of the splitter.
// Depends on etsp_pkg for the command type and depth.
module etsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  etsp_pkg::chunk_cmd_type push_cmd,
   output logic                    pop_valid,
   input  logic                    pop_take,
   output etsp_pkg::chunk_cmd_type pop_cmd
);
   import etsp_pkg::*;

   chunk_cmd_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_take && pop_valid;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/etsp_back.sv]
// Back end of the splitter: walks one request chunk by chunk and drives the
// registered result channel. Depends on etsp_pkg.
module etsp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [etsp_pkg::DEV_W-1:0]        device_base,
   input  logic                              pop_valid,
   output logic                              pop_take,
   input  etsp_pkg::chunk_cmd_type           pop_cmd,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [etsp_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_is_write,
   output logic [etsp_pkg::DEV_W-1:0]        rsp_device_address,
   output logic [etsp_pkg::WORD_W-1:0]       rsp_word_address,
   output logic [etsp_pkg::COUNT_W-1:0]      rsp_chunk_length,
   output logic [etsp_pkg::OFFSET_W-1:0]     rsp_buffer_offset,
   output logic                              rsp_last
);
   import etsp_pkg::*;

   back_state_type         state_ff, state_in;
   logic [ADDR_W-1:0]      cur_ff, cur_in;
   logic [START_W-1:0]     start_ff, start_in;
   logic [ADDR_W-1:0]      end_ff, end_in;
   logic                   wr_ff, wr_in;
   logic [CHUNK_CNT_W-1:0] n_ff, n_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic                   is_write_ff, is_write_in;
   logic [DEV_W-1:0]       dev_ff, dev_in;
   logic [WORD_W-1:0]      word_ff, word_in;
   logic [COUNT_W-1:0]     len_ff, len_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic                   last_ff, last_in;

   logic                   out_free;
   logic                   emit;
   logic [STOP_W-1:0]      cur_wide, end_wide, die_stop, page_stop, limit, stop;
   logic                   fin;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Chunk boundary for the current address: die end, page end for writes,
   // then the end of the request.
   assign cur_wide  = STOP_W'(cur_ff);
   assign end_wide  = STOP_W'(end_ff);
   assign die_stop  = ((cur_wide >> DIE_LOG2) + 1'b1) << DIE_LOG2;
   assign page_stop = ((cur_wide >> PAGE_LOG2) + 1'b1) << PAGE_LOG2;
   assign limit     = (wr_ff && (page_stop < die_stop)) ? page_stop : die_stop;
   assign stop      = (end_wide < limit) ? end_wide : limit;
   assign fin       = (stop >= end_wide) || (n_ff == CHUNK_CNT_W'(MAX_RESULTS - 1));

   // Sequencer: take a command when idle, emit one chunk per free cycle.
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      wr_in       = wr_ff;
      n_in        = n_ff;
      pop_take    = 1'b0;
      emit        = 1'b0;
      status_in   = status_ff;
      is_write_in = is_write_ff;
      dev_in      = dev_ff;
      word_in     = word_ff;
      len_in      = len_ff;
      offset_in   = offset_ff;
      last_in     = last_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (pop_valid && out_free) begin
               pop_take = 1'b1;
               if (pop_cmd.status != STATUS_OK) begin
                  // A rejected transaction yields one final result with zero address, length and offset.
                  emit        = 1'b1;
                  status_in   = pop_cmd.status;
                  is_write_in = pop_cmd.is_write;
                  dev_in      = '0;
                  word_in     = '0;
                  len_in      = '0;
                  offset_in   = '0;
                  last_in     = 1'b1;
               end else begin
                  cur_in   = ADDR_W'(pop_cmd.start_addr);
                  start_in = pop_cmd.start_addr;
                  end_in   = pop_cmd.end_addr;
                  wr_in    = pop_cmd.is_write;
                  n_in     = '0;
                  state_in = BACK_RUN;
               end
            end
         end
         BACK_RUN: begin
            if (out_free) begin
               emit        = 1'b1;
               status_in   = STATUS_OK;
               is_write_in = wr_ff;
               dev_in      = device_base | die_code(cur_ff[DIE_LOG2+1:DIE_LOG2]);
               word_in     = WORD_W'(cur_ff & ADDR_W'(DIE_BYTES - 1));
               len_in      = COUNT_W'(stop - cur_wide);
               offset_in   = OFFSET_W'(cur_ff - ADDR_W'(start_ff));
               last_in     = fin;
               cur_in      = ADDR_W'(stop);
               n_in        = n_ff + 1'b1;
               if (fin) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // The result register holds while the receiver stalls.
   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      wr_ff       <= wr_in;
      status_ff   <= status_in;
      is_write_ff <= is_write_in;
      dev_ff      <= dev_in;
      word_ff     <= word_in;
      len_ff      <= len_in;
      offset_ff   <= offset_in;
      last_ff     <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_is_write       = is_write_ff;
   assign rsp_device_address = dev_ff;
   assign rsp_word_address   = word_ff;
   assign rsp_chunk_length   = len_ff;
   assign rsp_buffer_offset  = offset_ff;
   assign rsp_last           = last_ff;

endmodule

[design/eeprom_transfer_splitter_top.sv]
// EEPROM transfer splitter, top level: front end, command queue, back end.
// Depends on etsp_pkg, etsp_front, etsp_queue and etsp_back.
//
// Usage:
//   req_* carries one transfer transaction (read/write flag, linear start
//   address over four dies, byte count). It is taken when req_valid is high
//   and req_stall is low; the front end checks it against top_limit and the
//   maximum length and places it in a two-entry command queue.
//   rsp_* carries the results: one rejection result, or one chunk descriptor
//   per cycle while rsp_stall is low, none crossing a die end and, for writes, none crossing a
//   128-byte page. The final result of each transaction has rsp_last set.
//   csr_* writes top_limit (index 0) or device_base (index 1); csr_ready is
//   always high. Write registers only while the block is idle.
// Flow (back end idle): a rejection passes from the command queue straight
//   into the result register; a good transaction passes through the queue,
//   then loads the sequencer, and its first chunk then enters the result
//   register, followed by one chunk per cycle while rsp_stall is low. A write
//   yields up to 33 chunks; the sequencer sets the throughput.
// Reset clears the queue, the sequencer, the result valid and restores the
// register defaults. A stall on rsp_stall holds the result register; the
// queue still takes up to two more transactions before req_stall rises.
module eeprom_transfer_splitter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [etsp_pkg::START_W-1:0]      req_start_address,
   input  logic [etsp_pkg::COUNT_W-1:0]      req_byte_count,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [etsp_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_is_write,
   output logic [etsp_pkg::DEV_W-1:0]        rsp_device_address,
   output logic [etsp_pkg::WORD_W-1:0]       rsp_word_address,
   output logic [etsp_pkg::COUNT_W-1:0]      rsp_chunk_length,
   output logic [etsp_pkg::OFFSET_W-1:0]     rsp_buffer_offset,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [etsp_pkg::ADDR_W-1:0]       csr_wdata
);
   import etsp_pkg::*;

   logic              push_valid, push_ready;
   chunk_cmd_type     push_cmd;
   logic              pop_valid, pop_take;
   chunk_cmd_type     pop_cmd;
   logic [DEV_W-1:0]  device_base;

   // Register file and classification.
   etsp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_start_address (req_start_address),
      .req_byte_count    (req_byte_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .device_base       (device_base),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_cmd          (push_cmd)
   );

   // Decouples classification from chunk generation.
   etsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_cmd    (pop_cmd)
   );

   // Chunk sequencer and result register.
   etsp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .device_base        (device_base),
      .pop_valid          (pop_valid),
      .pop_take           (pop_take),
      .pop_cmd            (pop_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_is_write       (rsp_is_write),
      .rsp_device_address (rsp_device_address),
      .rsp_word_address   (rsp_word_address),
      .rsp_chunk_length   (rsp_chunk_length),
      .rsp_buffer_offset  (rsp_buffer_offset),
      .rsp_last           (rsp_last)
   );

endmodule

[design/etsp_checker.sv]
// Port-level checks for the EEPROM transfer splitter, bound to the top level.
// Depends on etsp_pkg and eeprom_transfer_splitter_top.
module etsp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [etsp_pkg::STATUS_W-1:0]     rsp_status,
   input logic                              rsp_is_write,
   input logic [etsp_pkg::WORD_W-1:0]       rsp_word_address,
   input logic [etsp_pkg::COUNT_W-1:0]      rsp_chunk_length,
   input logic                              rsp_last
);
   import etsp_pkg::*;

   // A rejection is a single, empty, final transaction.
   a_reject_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last && (rsp_chunk_length == '0))
      else $error("rejection result not final or not empty");

   // A chunk never exceeds the maximum request length.
   a_chunk_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |-> (rsp_chunk_length <= COUNT_W'(MAX_REQUEST)))
      else $error("chunk longer than the maximum request");

   // A write chunk stays inside one page.
   a_write_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_write && (rsp_status == STATUS_OK) |->
         ((14'(rsp_word_address[PAGE_LOG2-1:0]) + 14'(rsp_chunk_length)) <= 14'(PAGE_BYTES)))
      else $error("write chunk crosses a page");

   // A stalled result stays offered.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its word address and last flag.
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_word_address) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind eeprom_transfer_splitter_top etsp_checker u_etsp_checker (.*);

[sim/eeprom_transfer_splitter_top_tb.sv]
// Self-checking testbench for eeprom_transfer_splitter_top: transfer transactions go in,
// chunk descriptors come out and are checked against a predictor kept in the bench.
// Depends on etsp_pkg and the eeprom_transfer_splitter_top design files.
module eeprom_transfer_splitter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import etsp_pkg::*;

   localparam int LONG_HOLD_CYCLES = 100;
   localparam int SETTLE_CYCLES    = 40;

   // One transfer transaction as offered on the request channel.
   typedef struct packed {
      logic               is_write;
      logic [START_W-1:0] start_address;
      logic [COUNT_W-1:0] byte_count;
   } transfer_type;

   // One chunk descriptor (or rejection) as seen on the result channel.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_write;
      logic [DEV_W-1:0]    device_address;
      logic [WORD_W-1:0]   word_address;
      logic [COUNT_W-1:0]  chunk_length;
      logic [OFFSET_W-1:0] buffer_offset;
      logic                last;
   } chunk_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = 1'b0;
   logic [START_W-1:0]  req_start_address = '0;
   logic [COUNT_W-1:0]  req_byte_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_is_write;
   logic [DEV_W-1:0]    rsp_device_address;
   logic [WORD_W-1:0]   rsp_word_address;
   logic [COUNT_W-1:0]  rsp_chunk_length;
   logic [OFFSET_W-1:0] rsp_buffer_offset;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = 1'b0;
   logic [ADDR_W-1:0]   csr_wdata = '0;

   // Register copies used by the predictor.
   int unsigned top_limit_cfg = 32'(TOP_LIMIT_RESET);
   int unsigned device_base_cfg = 32'(DEVICE_BASE_RESET);

   transfer_type pending_transfers[$];
   chunk_type    expected_chunks[$];
   transfer_type offered;
   int unsigned  send_wait = 0;
   int unsigned  recv_wait = 0;
   int unsigned  send_gap_max = 6;
   int unsigned  recv_gap_max = 6;
   int           transfers_accepted = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;
   int           mismatch_count = 0;

   eeprom_transfer_splitter_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_start_address  (req_start_address),
      .req_byte_count     (req_byte_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_is_write       (rsp_is_write),
      .rsp_device_address (rsp_device_address),
      .rsp_word_address   (rsp_word_address),
      .rsp_chunk_length   (rsp_chunk_length),
      .rsp_buffer_offset  (rsp_buffer_offset),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Cut one accepted transfer into the chunk descriptors the block must produce.
   function automatic void split_transfer(transfer_type t);
      int unsigned start, count, end_addr, cur, word, die_base, stop, page_end, sel;
      int          n;
      bit          fin;
      chunk_type   c;
      start = 32'(t.start_address);
      count = 32'(t.byte_count);
      end_addr = start + count;
      c = '0;
      c.is_write = t.is_write;
      c.last = 1'b1;
      if (start > top_limit_cfg || end_addr > top_limit_cfg) begin
         c.status = STATUS_RANGE;
         expected_chunks.push_back(c);
      end else if (count > MAX_REQUEST) begin
         c.status = STATUS_LENGTH;
         expected_chunks.push_back(c);
      end else begin
         cur = start;
         n = 0;
         fin = 1'b0;
         while (!fin) begin
            word = cur % DIE_BYTES;
            die_base = cur - word;
            stop = die_base + DIE_BYTES;
            // Writes additionally stop at the end of the current page.
            if (t.is_write) begin
               page_end = die_base + (word / PAGE_BYTES + 1) * PAGE_BYTES;
               if (page_end < stop) stop = page_end;
            end
            if (end_addr < stop) stop = end_addr;
            fin = (stop >= end_addr) || (n == MAX_RESULTS - 1);
            // Die index beyond the fourth die wraps onto the select codes.
            sel = 8 + 2 * ((cur / DIE_BYTES) % 4);
            c.status = STATUS_OK;
            c.device_address = DEV_W'(device_base_cfg | sel);
            c.word_address = WORD_W'(word);
            c.chunk_length = COUNT_W'(stop - cur);
            c.buffer_offset = OFFSET_W'(cur - start);
            c.last = fin;
            expected_chunks.push_back(c);
            n++;
            cur = stop;
         end
      end
   endfunction

   // Mostly well-formed transfers that fit under top_limit, aimed at page and die ends.
   function automatic transfer_type random_transfer();
      transfer_type t;
      int unsigned  roll, room, anchor, jitter;
      roll = $urandom_range(0, 9);
      t.is_write = 1'($urandom_range(0, 1));
      t.start_address = START_W'($urandom);
      t.byte_count = COUNT_W'($urandom);
      if (roll >= 2) begin
         case (roll)
            2: t.byte_count = COUNT_W'($urandom_range(MAX_REQUEST + 1, 8191));
            3, 4: t.byte_count = COUNT_W'($urandom_range(0, 16));
            5, 6, 7: t.byte_count = COUNT_W'($urandom_range(0, 400));
            default: t.byte_count = COUNT_W'($urandom_range(MAX_REQUEST - 200, MAX_REQUEST));
         endcase
         if (top_limit_cfg >= 32'(t.byte_count)) begin
            room = top_limit_cfg - 32'(t.byte_count);
            if (room > 32'h3FFFF) room = 32'h3FFFF;
            if ($urandom_range(0, 1) == 1) begin
               anchor = $urandom_range(0, room);
            end else begin
               if ($urandom_range(0, 1) == 1) anchor = $urandom_range(1, 4) << 16;
               else anchor = $urandom_range(0, 2047) << 7;
               jitter = $urandom_range(0, 300);
               anchor = (anchor > jitter) ? anchor - jitter : 0;
               if (anchor > room) anchor = room;
            end
            t.start_address = START_W'(anchor);
         end
      end
      return t;
   endfunction

   task automatic queue_transfer(input bit wr, input int unsigned start, input int unsigned count);
      transfer_type t;
      t.is_write = wr;
      t.start_address = START_W'(start);
      t.byte_count = COUNT_W'(count);
      pending_transfers.push_back(t);
   endtask

   task automatic queue_random(input int n);
      repeat (n) pending_transfers.push_back(random_transfer());
   endtask

   // Block is idle: nothing to send, nothing offered, nothing outstanding.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_transfers.size() != 0 || req_valid || expected_chunks.size() != 0);
   endtask

   task automatic write_register(input logic idx, input int unsigned value);
      bit taken;
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= ADDR_W'(value);
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      if (idx == CSR_TOP_LIMIT) top_limit_cfg = value & 32'h7FFFF;
      else device_base_cfg = value & 32'hFF;
   endtask

   task automatic report_mismatch(input string what, input chunk_type want,
                                  input chunk_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected st=%0d wr=%0d dev=%02h word=%04h len=%0d off=%0d last=%0d",
                  $realtime, what, want.status, want.is_write, want.device_address,
                  want.word_address, want.chunk_length, want.buffer_offset, want.last);
         $display("   got st=%0d wr=%0d dev=%02h word=%04h len=%0d off=%0d last=%0d",
                  got.status, got.is_write, got.device_address, got.word_address,
                  got.chunk_length, got.buffer_offset, got.last);
      end
   endtask

   // Request driver: offers queued transactions with a random gap after each one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            split_transfer(offered);
            transfers_accepted <= transfers_accepted + 1;
            send_wait = $urandom_range(0, send_gap_max);
         end
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_transfers.size() != 0) begin
               offered = pending_transfers.pop_front();
               req_valid <= 1'b1;
               req_opcode <= offered.is_write;
               req_start_address <= offered.start_address;
               req_byte_count <= offered.byte_count;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // One long receiver hold-off early in the run, so the queue fills and stalls the input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && transfers_accepted >= 6) begin
         hold_left <= LONG_HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor: checks each accepted chunk, then stalls for a random gap.
   always @(posedge clock) begin
      chunk_type seen;
      chunk_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.status = rsp_status;
            seen.is_write = rsp_is_write;
            seen.device_address = rsp_device_address;
            seen.word_address = rsp_word_address;
            seen.chunk_length = rsp_chunk_length;
            seen.buffer_offset = rsp_buffer_offset;
            seen.last = rsp_last;
            if (expected_chunks.size() == 0) begin
               report_mismatch("unexpected chunk", '0, seen);
            end else begin
               want = expected_chunks.pop_front();
               if (seen !== want) report_mismatch("chunk mismatch", want, seen);
            end
            recv_wait = $urandom_range(0, recv_gap_max);
         end
         rsp_stall <= (hold_left != 0) || (recv_wait > 0);
         if (recv_wait > 0) recv_wait--;
      end
   end

   // Stimulus phases, each under its own register setting.
   initial begin
      // Reset values: extremes, zero length, maximum chunk counts, rejections, die ends.
      queue_transfer(1'b0, 0, 0);
      queue_transfer(1'b1, 0, 0);
      queue_transfer(1'b0, 0, MAX_REQUEST);
      queue_transfer(1'b1, 32'h40, MAX_REQUEST);
      queue_transfer(1'b1, 0, MAX_REQUEST);
      queue_transfer(1'b0, 0, MAX_REQUEST + 1);
      queue_transfer(1'b1, 0, 8191);
      queue_transfer(1'b0, 32'h3FFFF, 0);
      queue_transfer(1'b1, 32'h3FFF0, 0);
      queue_transfer(1'b0, 32'h3FFF0, 1);
      queue_transfer(1'b0, 32'hFF00, 32'h100);
      queue_transfer(1'b0, 32'hFF00, 32'h200);
      queue_transfer(1'b1, 32'h1FFC0, 200);
      queue_transfer(1'b1, 32'h3F07F, 3);
      queue_transfer(1'b1, 32'h3FFFF, 8191);
      queue_random(50);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Widest top limit: dies past the fourth wrap onto the select codes; no idling.
      write_register(CSR_TOP_LIMIT, 32'h7FFFF);
      write_register(CSR_DEVICE_BASE, 32'h0);
      @(negedge clock);
      send_gap_max = 0;
      recv_gap_max = 0;
      queue_transfer(1'b1, 32'h3FF80, 32'h100);
      queue_transfer(1'b0, 32'h3F000, MAX_REQUEST);
      queue_transfer(1'b0, 32'h3FFFF, 8191);
      queue_random(40);
      wait_idle();

      // Zero top limit: only an empty transfer at address zero gets through.
      write_register(CSR_TOP_LIMIT, 0);
      write_register(CSR_DEVICE_BASE, 32'h7FFFF);
      @(negedge clock);
      send_gap_max = 3;
      recv_gap_max = 6;
      queue_transfer(1'b0, 0, 0);
      queue_transfer(1'b1, 0, 0);
      queue_transfer(1'b1, 0, 1);
      queue_random(15);
      wait_idle();

      // Top limit exactly at the end of the fourth die, random device base.
      write_register(CSR_TOP_LIMIT, 32'h40000);
      write_register(CSR_DEVICE_BASE, $urandom);
      @(negedge clock);
      send_gap_max = 6;
      recv_gap_max = 2;
      queue_random(45);
      wait_idle();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_chunks.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[eeprom_transfer_splitter_top.f]
design/etsp_pkg.sv
design/etsp_front.sv
design/etsp_queue.sv
design/etsp_back.sv
design/eeprom_transfer_splitter_top.sv
design/etsp_checker.sv
sim/eeprom_transfer_splitter_top_tb.sv
